[hw/rtl/interval_reservation_table_assert.svh]
// Assertion macros for the interval reservation table checker.
// No dependencies; included by the checker file only.
`ifndef INTERVAL_RESERVATION_TABLE_ASSERT_SVH
`define INTERVAL_RESERVATION_TABLE_ASSERT_SVH

// Checked at every clock edge outside reset.
`define IRT_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define IRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/irt_pkg.sv]
// Shared types, constants and the microcode program of the interval reservation table.
// No dependencies.
`timescale 1ns / 1ps

package irt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int TIME_WIDTH  = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W     = 2 * TIME_WIDTH;
  localparam int STEP_W      = 3;

  typedef logic [STEP_W-1:0] step_t;

  // program addresses
  localparam step_t STEP_WAIT   = 3'd0;
  localparam step_t STEP_START  = 3'd1;
  localparam step_t STEP_SCAN   = 3'd2;
  localparam step_t STEP_COMMIT = 3'd3;
  localparam step_t STEP_EMIT   = 3'd4;

  typedef enum logic [1:0] {
    ST_BOOKED   = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_FULL     = 2'd2,
    ST_INVALID  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ACCEPT,
    COND_BAD,
    COND_EMPTY,
    COND_HIT,
    COND_LAST,
    COND_SLOT
  } cond_e;

  typedef enum logic [2:0] {
    ACT_WAIT,
    ACT_START,
    ACT_SCAN,
    ACT_COMMIT,
    ACT_EMIT
  } act_e;

  // one control word: first matching jump wins, else nxt
  typedef struct packed {
    act_e  act;
    cond_e cond_a;
    step_t tgt_a;
    cond_e cond_b;
    step_t tgt_b;
    step_t nxt;
  } ucode_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic accept;
    logic bad;
    logic empty;
    logic hit;
    logic last;
    logic slot;
  } flags_t;

  function automatic ucode_t irt_ucode(step_t step);
    ucode_t w;
    unique case (step)
      STEP_WAIT:   w = '{ACT_WAIT,   COND_ACCEPT, STEP_START, COND_NEVER, STEP_WAIT,
                         STEP_WAIT};
      STEP_START:  w = '{ACT_START,  COND_BAD,    STEP_EMIT,  COND_EMPTY, STEP_COMMIT,
                         STEP_SCAN};
      STEP_SCAN:   w = '{ACT_SCAN,   COND_HIT,    STEP_EMIT,  COND_LAST,  STEP_COMMIT,
                         STEP_SCAN};
      STEP_COMMIT: w = '{ACT_COMMIT, COND_NEVER,  STEP_WAIT,  COND_NEVER, STEP_WAIT,
                         STEP_EMIT};
      STEP_EMIT:   w = '{ACT_EMIT,   COND_SLOT,   STEP_WAIT,  COND_NEVER, STEP_WAIT,
                         STEP_EMIT};
      default:     w = '{ACT_WAIT,   COND_NEVER,  STEP_WAIT,  COND_NEVER, STEP_WAIT,
                         STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/irt_store.sv]
// Interval store: one entry holds {end, start}; one write port, one registered read port.
// Depends on irt_pkg.
`timescale 1ns / 1ps

module irt_store (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [irt_pkg::IDX_W-1:0]   waddr_i,
  input  logic [irt_pkg::ENTRY_W-1:0] wdata_i,
  input  logic [irt_pkg::IDX_W-1:0]   raddr_i,
  output logic [irt_pkg::ENTRY_W-1:0] rdata_o
);

  logic [irt_pkg::ENTRY_W-1:0] mem_q [irt_pkg::TABLE_DEPTH];
  logic [irt_pkg::ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/irt_seq.sv]
// Microcode sequencer: step counter, program ROM lookup and conditional jumps.
// Depends on irt_pkg.
`timescale 1ns / 1ps

module irt_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  irt_pkg::flags_t  flags_i,
  output irt_pkg::act_e    act_o
);

  irt_pkg::step_t  step_q, step_d;
  irt_pkg::ucode_t word;

  function automatic logic cond_true(irt_pkg::cond_e c, irt_pkg::flags_t f);
    logic r;
    unique case (c)
      irt_pkg::COND_NEVER:  r = 1'b0;
      irt_pkg::COND_ACCEPT: r = f.accept;
      irt_pkg::COND_BAD:    r = f.bad;
      irt_pkg::COND_EMPTY:  r = f.empty;
      irt_pkg::COND_HIT:    r = f.hit;
      irt_pkg::COND_LAST:   r = f.last;
      irt_pkg::COND_SLOT:   r = f.slot;
      default:              r = 1'b0;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= irt_pkg::STEP_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  always_comb begin
    word = irt_pkg::irt_ucode(step_q);
    if (cond_true(word.cond_a, flags_i)) begin
      step_d = word.tgt_a;
    end else if (cond_true(word.cond_b, flags_i)) begin
      step_d = word.tgt_b;
    end else begin
      step_d = word.nxt;
    end
  end

  assign act_o = word.act;

endmodule

[hw/rtl/interval_reservation_table.sv]
// Interval reservation table: a bad interval (end <= start) goes straight to the result;
// else the N stored intervals (0..TABLE_DEPTH) are scanned, and an overlap found on the
// N-th entry ends the scan with no commit step, while a clean scan ends in a commit step.
// One request at a time: next request taken once the result is in the output register;
// the scan reads one entry per cycle, and a stalled result beat adds its stall.
// Reset (rst_ni low, async) empties the table by clearing the count; entries are not
// cleared. Depends on irt_pkg, irt_seq, irt_store.
`timescale 1ns / 1ps

module interval_reservation_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request beat
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] start_time, [63:32] end_time
  // result beat
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // [1:0] status, [7:2] zero
);

  localparam int TW = irt_pkg::TIME_WIDTH;

  irt_pkg::act_e   act;
  irt_pkg::flags_t flags;

  // request registers (payload, no reset)
  logic [TW-1:0] req_start_q, req_end_q;

  // scan index and table fill count
  logic [irt_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [irt_pkg::CNT_W-1:0] count_q, count_d;
  irt_pkg::status_e          status_q, status_d;

  // output register
  logic             out_valid_q, out_valid_d;
  irt_pkg::status_e out_status_q;

  // store ports
  logic                        st_we;
  logic [irt_pkg::IDX_W-1:0]   st_raddr;
  logic [irt_pkg::ENTRY_W-1:0] st_rdata;
  logic [TW-1:0]               rd_start, rd_end;
  logic                        tbl_full;

  irt_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .act_o   (act)
  );

  irt_store u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (count_q[irt_pkg::IDX_W-1:0]),
    .wdata_i ({req_end_q, req_start_q}),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  assign rd_start = st_rdata[TW-1:0];
  assign rd_end   = st_rdata[2*TW-1:TW];
  assign tbl_full = (count_q == irt_pkg::CNT_W'(irt_pkg::TABLE_DEPTH));

  assign s_axis_tready_o = (act == irt_pkg::ACT_WAIT);

  // condition flags for the program
  always_comb begin
    flags.accept = s_axis_tvalid_i && s_axis_tready_o;
    flags.bad    = (req_end_q <= req_start_q);
    flags.empty  = (count_q == '0);
    // half-open overlap against the entry read last cycle
    flags.hit    = (req_start_q < rd_end) && (req_end_q > rd_start);
    flags.last   = (({1'b0, idx_q} + irt_pkg::CNT_W'(1)) == count_q);
    flags.slot   = !out_valid_q || m_axis_tready_i;
  end

  // datapath actions per control word
  always_comb begin
    idx_d       = idx_q;
    count_d     = count_q;
    status_d    = status_q;
    st_we       = 1'b0;
    st_raddr    = '0;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    unique case (act)
      irt_pkg::ACT_WAIT: begin
      end
      irt_pkg::ACT_START: begin
        // invalid stands if the jump takes us straight to emit
        status_d = irt_pkg::ST_INVALID;
        idx_d    = '0;
        st_raddr = '0;
      end
      irt_pkg::ACT_SCAN: begin
        idx_d    = idx_q + 1'b1;
        st_raddr = idx_q + 1'b1;
        if (flags.hit) begin
          status_d = irt_pkg::ST_CONFLICT;
        end
      end
      irt_pkg::ACT_COMMIT: begin
        if (tbl_full) begin
          status_d = irt_pkg::ST_FULL;
        end else begin
          status_d = irt_pkg::ST_BOOKED;
          st_we    = 1'b1;
          count_d  = count_q + 1'b1;
        end
      end
      irt_pkg::ACT_EMIT: begin
        if (flags.slot) begin
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      status_q    <= irt_pkg::ST_BOOKED;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flags.accept) begin
      req_start_q <= s_axis_tdata_i[TW-1:0];
      req_end_q   <= s_axis_tdata_i[2*TW-1:TW];
    end
    if ((act == irt_pkg::ACT_EMIT) && flags.slot) begin
      out_status_q <= status_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_status_q};

endmodule

[hw/rtl/irt_checker.sv]
// Port-level checker for the interval reservation table, bound to the top level.
// Depends on interval_reservation_table_assert.svh and interval_reservation_table.
`timescale 1ns / 1ps
`include "interval_reservation_table_assert.svh"

module irt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  // stalled result beat holds
  `IRT_ASSERT_RUN(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "result beat dropped or changed while stalled")

  // pad bits of result stay zero
  `IRT_ASSERT_RUN(a_out_pad, m_axis_tvalid_o |-> (m_axis_tdata_o[7:2] == 6'd0), "result pad bits set")

  // one request at a time: no new request right after one is taken
  `IRT_ASSERT_RUN(a_one_at_a_time, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "request taken while previous still in work")

  // reset empties the output register by the next edge
  `IRT_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid_o, "result valid during reset")

endmodule

bind interval_reservation_table irt_checker u_irt_checker (.*);

[tb/sv/interval_reservation_table_tb.sv]
// Self-checking bench for interval_reservation_table: mirrors the booking table,
// drives request beats and checks every status beat. Depends on irt_pkg and the RTL.
`timescale 1ns / 1ps

module interval_reservation_table_tb;

  typedef logic [irt_pkg::TIME_WIDTH-1:0] stamp_t;

  localparam logic [63:0] TIME_MAX = (64'd1 << irt_pkg::TIME_WIDTH) - 64'd1;

  // Opening requests, packed {end_time, start_time}. Kept short so the table
  // still has room for the random part afterwards.
  localparam logic [63:0] OPENING_BEATS [20] = '{
    {32'h0000_0000, 32'h0000_0000},  // empty interval at zero
    {32'h0000_0000, 32'hFFFF_FFFF},  // reversed, full range
    {32'hFFFF_FFFF, 32'hFFFF_FFFF},  // empty interval at the top
    {32'h0000_0001, 32'h0000_0000},  // lowest slot
    {32'hFFFF_FFFF, 32'hFFFF_FFFE},  // highest slot
    {32'hFFFF_FFFF, 32'h0000_0000},  // whole range, hits both
    {32'h0000_0005, 32'h0000_0001},  // touches [0,1)
    {32'h0000_0006, 32'h0000_0004},  // overlaps [1,5)
    {32'h0000_0009, 32'h0000_0005},  // touches [1,5)
    {32'h0000_0200, 32'h0000_0100},
    {32'h0000_0300, 32'h0000_0080},  // contains [100,200)
    {32'h0000_0181, 32'h0000_0180},  // inside [100,200)
    {32'h0000_0200, 32'h0000_0100},  // identical
    {32'h0000_0201, 32'h0000_0200},  // touches the end
    {32'h0000_0100, 32'h0000_00FF},  // touches the start
    {32'h5555_5556, 32'h5555_5555},
    {32'hAAAA_AAAB, 32'hAAAA_AAAA},
    {32'h7FFF_FFFF, 32'h8000_0000},  // reversed
    {32'hFFFF_FFFF, 32'hFFFF_FFFD},  // overlaps the top slot
    {32'hFFFF_FFFE, 32'hFFFF_FFFD}   // touches the top slot
  };

  // Mirror of the booking table plus the queue of status codes still owed.
  class reservation_checker;
    stamp_t           starts [irt_pkg::TABLE_DEPTH];
    stamp_t           ends   [irt_pkg::TABLE_DEPTH];
    int unsigned      count;
    irt_pkg::status_e expected_status [$];
    int unsigned      fails;

    // Decide the answer for [s, e) and book it if it fits.
    function irt_pkg::status_e book_or_refuse(stamp_t s, stamp_t e);
      if (e <= s) return irt_pkg::ST_INVALID;
      for (int i = 0; i < count; i++) begin
        if (s < ends[i] && e > starts[i]) return irt_pkg::ST_CONFLICT;
      end
      if (count >= irt_pkg::TABLE_DEPTH) return irt_pkg::ST_FULL;
      starts[count] = s;
      ends[count]   = e;
      count++;
      return irt_pkg::ST_BOOKED;
    endfunction

    function void note_request(stamp_t s, stamp_t e);
      expected_status.push_back(book_or_refuse(s, e));
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      fails++;
    endtask

    task check_result(logic [7:0] beat);
      irt_pkg::status_e want;
      irt_pkg::status_e got;
      if (expected_status.size() == 0) begin
        report($sformatf("status beat %02h with no request outstanding", beat));
      end else begin
        want = expected_status.pop_front();
        got  = irt_pkg::status_e'(beat[1:0]);
        if (got !== want)
          report($sformatf("status %s (%b), expected %s", got.name(), beat[1:0], want.name()));
        if (beat[7:2] !== 6'd0)
          report($sformatf("status beat padding %b not zero", beat[7:2]));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [63:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_data;

  reservation_checker sb;

  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned hold_cycles;  // long receiver hold-off, counted down by the sink

  interval_reservation_table dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic stamp_t clamp_stamp(logic [63:0] v);
    return (v > TIME_MAX) ? TIME_MAX[irt_pkg::TIME_WIDTH-1:0] : v[irt_pkg::TIME_WIDTH-1:0];
  endfunction

  // Mostly short lengths, now and then one across the whole range.
  function automatic logic [63:0] random_span();
    int unsigned k;
    if ($urandom_range(0, 15) == 0) return 64'($urandom) + 64'd1;
    k = $urandom_range(0, 20);
    return 64'($urandom_range(1, 32'd1 << k));
  endfunction

  // Requests are aimed at the current table: hits on stored intervals,
  // neighbors that just touch one, fresh slots and bad intervals.
  function automatic void make_request(output stamp_t s, output stamp_t e);
    int unsigned pick;
    int unsigned idx;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] p;
    logic [63:0] span;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // end at or below start
      s  = $urandom;
      lo = 64'(s);
      e  = ($urandom_range(0, 3) == 0) ? s : stamp_t'(lo - ({$urandom, $urandom} % (lo + 1)));
    end else if (pick < 50 && sb.count > 0) begin
      // cover some point of a stored interval
      idx  = $urandom_range(0, sb.count - 1);
      lo   = 64'(sb.starts[idx]);
      hi   = 64'(sb.ends[idx]);
      p    = lo + ({$urandom, $urandom} % (hi - lo));
      span = ($urandom_range(0, 3) == 0) ? 64'd0 : random_span();
      s    = (p > span) ? stamp_t'(p - span) : '0;
      e    = clamp_stamp(p + 64'd1 + (($urandom_range(0, 3) == 0) ? 64'd0 : random_span()));
    end else if (pick < 65 && sb.count > 0) begin
      // share an endpoint with a stored interval
      idx = $urandom_range(0, sb.count - 1);
      if ($urandom_range(0, 1) == 0) begin
        s = sb.ends[idx];
        e = clamp_stamp(64'(s) + random_span());
      end else begin
        e    = sb.starts[idx];
        span = random_span();
        s    = (64'(e) > span) ? stamp_t'(64'(e) - span) : '0;
      end
    end else begin
      s = $urandom;
      e = clamp_stamp(64'(s) + random_span());
    end
  endfunction

  // Offer one request beat, with an optional idle burst in front of it.
  task automatic send_request(stamp_t s, stamp_t e);
    int unsigned gap;
    gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    repeat (gap) begin
      @(negedge clk);
      s_valid <= 1'b0;
      s_data  <= {$urandom, $urandom};
    end
    @(negedge clk);
    s_valid <= 1'b1;
    s_data  <= {e, s};
    do @(posedge clk); while (!s_ready);
    sb.note_request(s, e);
  endtask

  task automatic run_phase(int unsigned n, bit tx_idle, bit rx_idle);
    stamp_t s;
    stamp_t e;
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    repeat (n) begin
      make_request(s, e);
      send_request(s, e);
    end
  endtask

  // Status sink: ready changes on the falling edge, beats are taken on the rising edge.
  initial begin
    int unsigned rx_gap;
    rx_gap = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_ready <= 1'b0;
        hold_cycles--;
      end else if (rx_gap > 0) begin
        m_ready <= 1'b0;
        rx_gap--;
      end else begin
        m_ready <= 1'b1;
        if (rx_idle_on && $urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 14);
      end
      @(posedge clk);
      if (m_valid && m_ready) sb.check_result(m_data);
    end
  end

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // endpoints, touching and nested intervals, bad intervals
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    foreach (OPENING_BEATS[i]) send_request(OPENING_BEATS[i][31:0], OPENING_BEATS[i][63:32]);

    run_phase(600, 1'b1, 1'b1);
    // sink goes quiet while requests keep coming, so the block backs up
    hold_cycles = 400;
    run_phase(500, 1'b0, 1'b1);
    run_phase(400, 1'b1, 1'b0);
    run_phase(400, 1'b0, 1'b0);

    @(negedge clk);
    s_valid <= 1'b0;
    while (sb.expected_status.size() != 0) @(posedge clk);
    // slack for a stray extra beat, longer than a full scan
    repeat (2 * irt_pkg::TABLE_DEPTH + 8) @(posedge clk);

    if (sb.fails == 0 && sb.expected_status.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
